@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold while out of reset
`define CHK_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// ante implies cons in the same cycle
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/pit_pkg.sv @@
`default_nettype none

package pit_pkg;

    localparam int ACC_W  = 64;
    localparam int MPLR_W = 33;
    localparam int DVD_W  = 38;
    localparam int DSR_W  = 33;
    localparam int CNT_W  = 6;
    localparam int NS_W   = 30;

    localparam logic [DVD_W-1:0] NS_PER_SEC = DVD_W'(1000000000);

    typedef enum logic [1:0] {
        REG_MAIN_COUNT = 2'd0,
        REG_PLL_MUL    = 2'd1,
        REG_PLL_DIV    = 2'd2,
        REG_PERIOD     = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ARM  = 1'b1
    } t_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

`default_nettype wire

@@ rtl/pit_mul.sv @@
`default_nettype none

module pit_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [pit_pkg::ACC_W-1:0]  i_acc,
    input  wire logic [pit_pkg::ACC_W-1:0]  i_mcand,
    input  wire logic [pit_pkg::MPLR_W-1:0] i_mplr,
    output pit_pkg::t_unit_sts              o_sts,
    output logic      [pit_pkg::ACC_W-1:0]  o_acc
);
    import pit_pkg::*;

    // shift-add: one multiplier bit per cycle, added straight into the accumulator
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_mcand;
    logic [MPLR_W-1:0] r_mplr;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_acc   <= i_acc;
            r_mcand <= i_mcand;
            r_mplr  <= i_mplr;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            if (r_mplr == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                if (r_mplr[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand <= {r_mcand[ACC_W-2:0], 1'b0};
                r_mplr  <= {1'b0, r_mplr[MPLR_W-1:1]};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_acc      = r_acc;

endmodule

`default_nettype wire

@@ rtl/pit_div.sv @@
`default_nettype none

`include "assert_macros.svh"

module pit_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [pit_pkg::DVD_W-1:0] i_dividend,
    input  wire logic [pit_pkg::DSR_W-1:0] i_divisor,
    output pit_pkg::t_unit_sts             o_sts,
    output logic      [pit_pkg::DVD_W-1:0] o_quot
);
    import pit_pkg::*;

    // restoring division, one quotient bit per cycle; dividend shifts out as quotient shifts in
    logic [DVD_W-1:0] r_q;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DSR_W:0]   rem_sh;
    logic             q_bit;
    logic [DSR_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[DVD_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_dsr});
        rem_sub = rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_q    <= i_dividend;
            r_dsr  <= i_divisor;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            if (r_cnt == CNT_W'(DVD_W-1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

    `CHK_IMPLY(a_div_cnt_range, i_clk, i_rst_n, r_busy, r_cnt <= CNT_W'(DVD_W-1), "divider step count past end")
    `CHK_NEVER(a_div_done_busy, i_clk, i_rst_n, r_done && r_busy && !$past(i_start), "divider done while still stepping")

endmodule

`default_nettype wire

@@ rtl/pit_tick_to_ns_alarm.sv @@
`default_nettype none

`include "assert_macros.svh"

// Nanosecond timekeeper for a periodic interval timer. Each request is either an
// arm (new_deadline is stored, zero disarms) or a tick sample, whose count and
// overflow fields are scaled by the nanoseconds per timer cycle and added to a 64-bit
// time; an armed deadline that the time has reached raises alarm once. The
// nanoseconds per timer cycle are derived from the main count, PLL multiplier and PLL
// divider registers and cached: the first tick after any register write recomputes
// them with one bit-serial shift-add pass and up to two restoring divisions. A tick
// then costs one shift-add pass per product: one for the overflow product and one for
// the time product. A tick with a clock error skips both products, and an arm skips
// all arithmetic. The input is free again in the cycle after the result is loaded.
// One request is in work at a time; the result sits in an output register so the
// next request can be taken while it waits. A zero divider or zero tick clock gives
// clock_error and leaves the time unchanged.
module pit_tick_to_ns_alarm (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_timer_value,
    input  wire logic [63:0] i_new_deadline,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_alarm,
    output logic             o_clock_error,
    output logic [63:0]      o_elapsed_ns,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pit_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLL_MUL,
        S_PLL_MUL_W,
        S_PLL_DIV_W,
        S_NS_DIV_W,
        S_N_MUL,
        S_N_MUL_W,
        S_T_MUL,
        S_T_MUL_W,
        S_CHECK,
        S_OUT
    } t_state;

    t_state r_state;

    logic [15:0] r_main;
    logic [10:0] r_mult;
    logic [3:0]  r_pdiv;
    logic [19:0] r_period;
    logic        cfg_wr;

    logic [63:0] r_time;
    logic [63:0] r_deadline;
    logic [NS_W-1:0] r_ns;
    logic        r_ns_ok;
    logic [19:0] r_count;
    logic [11:0] r_ovf;
    logic [MPLR_W-1:0] r_n;
    logic        r_alarm;
    logic        r_err;

    logic        r_o_valid;
    logic        r_o_alarm;
    logic        r_o_err;
    logic [63:0] r_o_elapsed;

    logic              r_mul_start;
    logic [ACC_W-1:0]  r_mul_acc;
    logic [ACC_W-1:0]  r_mul_mcand;
    logic [MPLR_W-1:0] r_mul_mplr;
    t_unit_sts         mul_sts;
    logic [ACC_W-1:0]  mul_res;
    logic              mul_wait;

    logic              r_div_start;
    logic [DVD_W-1:0]  r_div_dvd;
    logic [DSR_W-1:0]  r_div_dsr;
    t_unit_sts         div_sts;
    logic [DVD_W-1:0]  div_q;
    logic [DSR_W-1:0]  tick;

    pit_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_acc   (r_mul_acc),
        .i_mcand (r_mul_mcand),
        .i_mplr  (r_mul_mplr),
        .o_sts   (mul_sts),
        .o_acc   (mul_res)
    );

    pit_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dsr),
        .o_sts      (div_sts),
        .o_quot     (div_q)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign tick   = div_q[DVD_W-1:5];

    always_ff @(posedge i_clk) begin
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_MAIN_COUNT: r_main   <= pwdata[15:0];
                REG_PLL_MUL:    r_mult   <= pwdata[10:0];
                REG_PLL_DIV:    r_pdiv   <= pwdata[3:0];
                REG_PERIOD:     r_period <= pwdata[19:0];
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_main   <= '0;
            r_mult   <= '0;
            r_pdiv   <= '0;
            r_period <= '0;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAIN_COUNT: prdata = {16'd0, r_main};
            REG_PLL_MUL:    prdata = {21'd0, r_mult};
            REG_PLL_DIV:    prdata = {28'd0, r_pdiv};
            REG_PERIOD:     prdata = {12'd0, r_period};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mul_start <= 1'b0;
        r_div_start <= 1'b0;
        if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_alarm <= 1'b0;
                    r_err   <= 1'b0;
                    if (i_operation == OP_ARM) begin
                        r_deadline <= i_new_deadline;
                        r_state    <= S_OUT;
                    end else begin
                        r_count <= i_timer_value[19:0];
                        r_ovf   <= i_timer_value[31:20];
                        r_state <= r_ns_ok ? S_N_MUL : S_PLL_MUL;
                    end
                end
            end
            S_PLL_MUL: begin
                r_mul_start <= 1'b1;
                r_mul_acc   <= '0;
                r_mul_mcand <= {37'd0, r_main, 11'd0};
                r_mul_mplr  <= {22'd0, r_mult};
                r_state     <= S_PLL_MUL_W;
            end
            S_PLL_MUL_W: begin
                if (mul_sts.done) begin
                    if (r_pdiv == '0) begin
                        r_ns    <= '0;
                        r_ns_ok <= 1'b1;
                        r_state <= S_N_MUL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_dvd   <= mul_res[DVD_W-1:0];
                        r_div_dsr   <= {29'd0, r_pdiv};
                        r_state     <= S_PLL_DIV_W;
                    end
                end
            end
            S_PLL_DIV_W: begin
                if (div_sts.done) begin
                    if (tick == '0) begin
                        r_ns    <= '0;
                        r_ns_ok <= 1'b1;
                        r_state <= S_N_MUL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_dvd   <= NS_PER_SEC;
                        r_div_dsr   <= tick;
                        r_state     <= S_NS_DIV_W;
                    end
                end
            end
            S_NS_DIV_W: begin
                if (div_sts.done) begin
                    r_ns    <= div_q[NS_W-1:0] + 1'b1;
                    r_ns_ok <= 1'b1;
                    r_state <= S_N_MUL;
                end
            end
            S_N_MUL: begin
                if (r_ns == '0) begin
                    r_err   <= 1'b1;
                    r_state <= S_CHECK;
                end else begin
                    r_mul_start <= 1'b1;
                    r_mul_acc   <= {44'd0, r_count};
                    r_mul_mcand <= {44'd0, r_period};
                    r_mul_mplr  <= {21'd0, r_ovf};
                    r_state     <= S_N_MUL_W;
                end
            end
            S_N_MUL_W: begin
                if (mul_sts.done) begin
                    r_n     <= mul_res[MPLR_W-1:0];
                    r_state <= S_T_MUL;
                end
            end
            S_T_MUL: begin
                r_mul_start <= 1'b1;
                r_mul_acc   <= r_time;
                r_mul_mcand <= {34'd0, r_ns};
                r_mul_mplr  <= r_n;
                r_state     <= S_T_MUL_W;
            end
            S_T_MUL_W: begin
                if (mul_sts.done) begin
                    r_time  <= mul_res;
                    r_state <= S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_deadline != '0 && r_time >= r_deadline) begin
                    r_alarm    <= 1'b1;
                    r_deadline <= '0;
                end
                r_state <= S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    r_o_valid   <= 1'b1;
                    r_o_alarm   <= r_alarm;
                    r_o_err     <= r_err;
                    r_o_elapsed <= r_time;
                    r_state     <= S_IDLE;
                end
            end
            default: r_state <= S_IDLE;
        endcase
        if (cfg_wr) begin
            r_ns_ok <= 1'b0;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_ns_ok     <= 1'b0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_time      <= '0;
            r_deadline  <= '0;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_alarm       = r_o_alarm;
    assign o_clock_error = r_o_err;
    assign o_elapsed_ns  = r_o_elapsed;

    assign mul_wait = r_state inside {S_PLL_MUL_W, S_N_MUL_W, S_T_MUL_W};

    `CHK_NEVER(a_units_exclusive, i_clk, i_rst_n, mul_sts.busy && div_sts.busy, "both units busy")
    `CHK_IMPLY(a_mul_done_wait, i_clk, i_rst_n, mul_sts.done, mul_wait, "mul done outside wait")
    `CHK_IMPLY(a_disarm, i_clk, i_rst_n, r_state == S_OUT && r_alarm, r_deadline == '0, "armed")

endmodule

`default_nettype wire
